### design/plaf_pkg.sv
// shared types, register map and step codes of the lattice action and force block
package plaf_pkg;

    localparam int unsigned MAX_SITES = 1024;
    localparam int unsigned SITE_W    = 10;
    localparam int unsigned LEN_W     = 11;
    localparam int unsigned POS_W     = 24;
    localparam int unsigned COEF_W    = 32;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned IDX_W     = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PATH_LENGTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_KINETIC_COEF = 3'd1;
    localparam logic [IDX_W-1:0] REG_MASS_COEF    = 3'd2;
    localparam logic [IDX_W-1:0] REG_ACTION_SCALE = 3'd3;
    localparam logic [IDX_W-1:0] REG_FORCE_SCALE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FORCE_DIAG   = 3'd5;

    // register reset values
    localparam logic [LEN_W-1:0]  RST_PATH_LENGTH  = 11'd64;
    localparam logic [COEF_W-1:0] RST_KINETIC_COEF = 32'd65536;
    localparam logic [COEF_W-1:0] RST_MASS_COEF    = 32'd65536;
    localparam logic [COEF_W-1:0] RST_ACTION_SCALE = 32'd32768;
    localparam logic [COEF_W-1:0] RST_FORCE_SCALE  = 32'd65536;
    localparam logic [COEF_W-1:0] RST_FORCE_DIAG   = 32'd196608;

    // multiplier steps
    localparam logic [3:0] MUL_NONE = 4'd0;
    localparam logic [3:0] MUL_SQ   = 4'd1;
    localparam logic [3:0] MUL_TLO  = 4'd2;
    localparam logic [3:0] MUL_THI  = 4'd3;
    localparam logic [3:0] MUL_DIAG = 4'd4;
    localparam logic [3:0] MUL_FLO  = 4'd5;
    localparam logic [3:0] MUL_FHI  = 4'd6;
    localparam logic [3:0] MUL_ALO  = 4'd7;
    localparam logic [3:0] MUL_AHI  = 4'd8;

    // sources of the squared terms: a position difference or, for the mass term, the position
    localparam logic [1:0] SQ_KIN  = 2'd0;
    localparam logic [1:0] SQ_MASS = 2'd1;
    localparam logic [1:0] SQ_WRAP = 2'd2;

    // force stencils
    localparam logic [1:0] FRC_MID  = 2'd0;
    localparam logic [1:0] FRC_END  = 2'd1;
    localparam logic [1:0] FRC_ZERO = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  path_length;
        logic [COEF_W-1:0] kinetic_coef;
        logic [COEF_W-1:0] mass_coef;
        logic [COEF_W-1:0] action_scale;
        logic [COEF_W-1:0] force_scale;
        logic [COEF_W-1:0] force_diag;
    } t_cfg;

    typedef struct packed {
        logic              load_x;
        logic [3:0]        mul_op;
        logic [1:0]        sq_src;
        logic              use_mass;
        logic [1:0]        frc_src;
        logic              acc;
        logic              inner;
        logic              shift;
        logic              store_first;
        logic              store_second;
        logic              emit_force;
        logic              emit_action;
        logic [SITE_W-1:0] site;
        logic              clear_sum;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

### design/periodic_lattice_action_and_force_top.sv
// top level of the periodic lattice action and force block
// one word per site, taken only while the sequencer is idle: one shared 32x32 multiplier
// steps through every product of a site before the next site is taken
// the force word of a site shows after the next site is taken; the closing site adds
// two wrap-around forces and the action; a stalled output holds the sequencer
// reset is synchronous, active low: registers go to their defaults and the path restarts
module periodic_lattice_action_and_force_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [plaf_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [plaf_pkg::POS_W-1:0]   i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_result_kind,
    output logic [plaf_pkg::SITE_W-1:0]         o_site,
    output logic signed [plaf_pkg::VALUE_W-1:0] o_value,
    output logic                                o_last
);

    plaf_pkg::t_cfg  cfg;
    plaf_pkg::t_cmd  cmd;
    plaf_pkg::t_stat stat;

    plaf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    plaf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_path_length (cfg.path_length),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    plaf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_site        (o_site),
        .o_value       (o_value),
        .o_last        (o_last)
    );

endmodule

### design/plaf_regs.sv
// configuration register file with apb-style access
module plaf_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plaf_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output plaf_pkg::t_cfg                o_cfg
);

    plaf_pkg::t_cfg             r_cfg;
    logic [plaf_pkg::IDX_W-1:0] idx;
    logic                       wr;

    assign idx    = paddr[plaf_pkg::ADDR_W-1:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.path_length  <= plaf_pkg::RST_PATH_LENGTH;
            r_cfg.kinetic_coef <= plaf_pkg::RST_KINETIC_COEF;
            r_cfg.mass_coef    <= plaf_pkg::RST_MASS_COEF;
            r_cfg.action_scale <= plaf_pkg::RST_ACTION_SCALE;
            r_cfg.force_scale  <= plaf_pkg::RST_FORCE_SCALE;
            r_cfg.force_diag   <= plaf_pkg::RST_FORCE_DIAG;
        end else if (wr) begin
            case (idx)
                plaf_pkg::REG_PATH_LENGTH:  r_cfg.path_length  <= pwdata[plaf_pkg::LEN_W-1:0];
                plaf_pkg::REG_KINETIC_COEF: r_cfg.kinetic_coef <= pwdata;
                plaf_pkg::REG_MASS_COEF:    r_cfg.mass_coef    <= pwdata;
                plaf_pkg::REG_ACTION_SCALE: r_cfg.action_scale <= pwdata;
                plaf_pkg::REG_FORCE_SCALE:  r_cfg.force_scale  <= pwdata;
                plaf_pkg::REG_FORCE_DIAG:   r_cfg.force_diag   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            plaf_pkg::REG_PATH_LENGTH:  prdata = {21'd0, r_cfg.path_length};
            plaf_pkg::REG_KINETIC_COEF: prdata = r_cfg.kinetic_coef;
            plaf_pkg::REG_MASS_COEF:    prdata = r_cfg.mass_coef;
            plaf_pkg::REG_ACTION_SCALE: prdata = r_cfg.action_scale;
            plaf_pkg::REG_FORCE_SCALE:  prdata = r_cfg.force_scale;
            plaf_pkg::REG_FORCE_DIAG:   prdata = r_cfg.force_diag;
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

### design/plaf_ctrl.sv
// step sequencer: site counter, path end detection and datapath commands
module plaf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [plaf_pkg::LEN_W-1:0]  i_path_length,
    input  plaf_pkg::t_stat             i_stat,
    output plaf_pkg::t_cmd              o_cmd
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_KSQ  = 5'd1;
    localparam logic [4:0] ST_KLO  = 5'd2;
    localparam logic [4:0] ST_KHI  = 5'd3;
    localparam logic [4:0] ST_MSQ  = 5'd4;
    localparam logic [4:0] ST_MLO  = 5'd5;
    localparam logic [4:0] ST_MHI  = 5'd6;
    localparam logic [4:0] ST_MACC = 5'd7;
    localparam logic [4:0] ST_FD   = 5'd8;
    localparam logic [4:0] ST_FI   = 5'd9;
    localparam logic [4:0] ST_FL   = 5'd10;
    localparam logic [4:0] ST_FH   = 5'd11;
    localparam logic [4:0] ST_FO   = 5'd12;
    localparam logic [4:0] ST_WSQ  = 5'd13;
    localparam logic [4:0] ST_WLO  = 5'd14;
    localparam logic [4:0] ST_WHI  = 5'd15;
    localparam logic [4:0] ST_WACC = 5'd16;
    localparam logic [4:0] ST_ALO  = 5'd17;
    localparam logic [4:0] ST_AHI  = 5'd18;
    localparam logic [4:0] ST_AO   = 5'd19;

    localparam logic [plaf_pkg::LEN_W-1:0] LEN_MIN = 11'd3;
    localparam logic [plaf_pkg::LEN_W-1:0] LEN_MAX = plaf_pkg::LEN_W'(plaf_pkg::MAX_SITES);

    logic [4:0]                  r_state, n_state;
    logic [plaf_pkg::SITE_W-1:0] r_cnt, n_cnt;
    logic                        r_last, n_last;
    logic [1:0]                  r_fsel, n_fsel;
    logic [plaf_pkg::LEN_W-1:0]  len_eff;
    logic                        is_last;
    logic [plaf_pkg::SITE_W-1:0] cnt_inc;

    always_comb begin
        if (i_path_length < LEN_MIN) begin
            len_eff = LEN_MIN;
        end else if (i_path_length > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = i_path_length;
        end
    end

    assign is_last    = (r_cnt >= plaf_pkg::SITE_W'(2)) &&
                        ({1'b0, r_cnt} >= (len_eff - plaf_pkg::LEN_W'(1)));
    assign cnt_inc    = r_cnt + plaf_pkg::SITE_W'(1);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_fsel  = r_fsel;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_last       = is_last;
                    n_state      = (r_cnt == '0) ? ST_MSQ : ST_KSQ;
                end
            end
            ST_KSQ: begin
                o_cmd.mul_op = plaf_pkg::MUL_SQ;
                o_cmd.sq_src = plaf_pkg::SQ_KIN;
                n_state      = ST_KLO;
            end
            ST_KLO: begin
                o_cmd.mul_op = plaf_pkg::MUL_TLO;
                n_state      = ST_KHI;
            end
            ST_KHI: begin
                o_cmd.mul_op = plaf_pkg::MUL_THI;
                n_state      = ST_MSQ;
            end
            ST_MSQ: begin
                o_cmd.mul_op = plaf_pkg::MUL_SQ;
                o_cmd.sq_src = plaf_pkg::SQ_MASS;
                o_cmd.acc    = (r_cnt != '0);
                n_state      = ST_MLO;
            end
            ST_MLO: begin
                o_cmd.mul_op   = plaf_pkg::MUL_TLO;
                o_cmd.use_mass = 1'b1;
                n_state        = ST_MHI;
            end
            ST_MHI: begin
                o_cmd.mul_op   = plaf_pkg::MUL_THI;
                o_cmd.use_mass = 1'b1;
                n_state        = ST_MACC;
            end
            ST_MACC: begin
                o_cmd.acc          = 1'b1;
                o_cmd.mul_op       = plaf_pkg::MUL_DIAG;
                o_cmd.frc_src      = plaf_pkg::FRC_MID;
                o_cmd.shift        = 1'b1;
                o_cmd.store_first  = (r_cnt == plaf_pkg::SITE_W'(0));
                o_cmd.store_second = (r_cnt == plaf_pkg::SITE_W'(1));
                if (r_cnt >= plaf_pkg::SITE_W'(2)) begin
                    n_fsel  = plaf_pkg::FRC_MID;
                    n_state = ST_FI;
                end else begin
                    n_cnt   = cnt_inc;
                    n_state = ST_IDLE;
                end
            end
            ST_FD: begin
                o_cmd.mul_op  = plaf_pkg::MUL_DIAG;
                o_cmd.frc_src = r_fsel;
                n_state       = ST_FI;
            end
            ST_FI: begin
                o_cmd.inner = 1'b1;
                n_state     = ST_FL;
            end
            ST_FL: begin
                o_cmd.mul_op = plaf_pkg::MUL_FLO;
                n_state      = ST_FH;
            end
            ST_FH: begin
                o_cmd.mul_op = plaf_pkg::MUL_FHI;
                n_state      = ST_FO;
            end
            ST_FO: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_force = 1'b1;
                    case (r_fsel)
                        plaf_pkg::FRC_MID: begin
                            o_cmd.site = r_cnt - plaf_pkg::SITE_W'(1);
                            if (r_last) begin
                                n_fsel  = plaf_pkg::FRC_END;
                                n_state = ST_FD;
                            end else begin
                                n_cnt   = cnt_inc;
                                n_state = ST_IDLE;
                            end
                        end
                        plaf_pkg::FRC_END: begin
                            o_cmd.site = r_cnt;
                            n_fsel     = plaf_pkg::FRC_ZERO;
                            n_state    = ST_FD;
                        end
                        default: begin
                            o_cmd.site = '0;
                            n_state    = ST_WSQ;
                        end
                    endcase
                end
            end
            ST_WSQ: begin
                o_cmd.mul_op = plaf_pkg::MUL_SQ;
                o_cmd.sq_src = plaf_pkg::SQ_WRAP;
                n_state      = ST_WLO;
            end
            ST_WLO: begin
                o_cmd.mul_op = plaf_pkg::MUL_TLO;
                n_state      = ST_WHI;
            end
            ST_WHI: begin
                o_cmd.mul_op = plaf_pkg::MUL_THI;
                n_state      = ST_WACC;
            end
            ST_WACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_ALO;
            end
            ST_ALO: begin
                o_cmd.mul_op = plaf_pkg::MUL_ALO;
                n_state      = ST_AHI;
            end
            ST_AHI: begin
                o_cmd.mul_op = plaf_pkg::MUL_AHI;
                n_state      = ST_AO;
            end
            ST_AO: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_action = 1'b1;
                    o_cmd.clear_sum   = 1'b1;
                    n_cnt             = '0;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_fsel  <= plaf_pkg::FRC_MID;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_fsel  <= n_fsel;
        end
    end

endmodule

### design/plaf_dp.sv
// datapath: position window, shared 32x32 multiplier, action sum and output word register
module plaf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  plaf_pkg::t_cfg                      i_cfg,
    input  plaf_pkg::t_cmd                      i_cmd,
    output plaf_pkg::t_stat                     o_stat,
    input  logic signed [plaf_pkg::POS_W-1:0]   i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_result_kind,
    output logic [plaf_pkg::SITE_W-1:0]         o_site,
    output logic signed [plaf_pkg::VALUE_W-1:0] o_value,
    output logic                                o_last
);

    logic signed [23:0] r_x, r_first, r_second, r_prev, r_bprev;

    logic [47:0]        r_sq;
    logic [54:0]        r_fp;
    logic               r_cneg;
    logic signed [24:0] r_lr;
    logic [55:0]        r_imag;
    logic               r_ineg;
    logic [63:0]        r_plo;
    logic [63:0]        r_phi;
    logic [63:0]        r_sum;

    logic               r_ovalid;
    logic               r_okind;
    logic [9:0]         r_osite;
    logic [63:0]        r_ovalue;
    logic               r_olast;

    // squared term operand
    logic signed [24:0] sq_diff, sq_abs;
    logic [23:0]        sq_mag;

    // force stencil operands
    logic signed [23:0] f_c, f_l, f_r;
    logic signed [24:0] f_c_abs;

    // multiplier
    logic [31:0]        coef;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    // inner bracket
    logic signed [56:0] fp_s, lr_sh, inner, inner_abs;

    // results
    logic [56:0]        frc_p;
    logic               frc_big;
    logic [63:0]        frc_val;
    logic [63:0]        term;
    logic [64:0]        acc_s;
    logic [63:0]        sum_next;
    logic [80:0]        act_tot;
    logic [63:0]        act_val;
    logic               out_free;

    always_comb begin
        case (i_cmd.sq_src)
            plaf_pkg::SQ_KIN:  sq_diff = {r_x[23], r_x} - {r_prev[23], r_prev};
            plaf_pkg::SQ_MASS: sq_diff = {r_x[23], r_x};
            plaf_pkg::SQ_WRAP: sq_diff = {r_first[23], r_first} - {r_x[23], r_x};
            default:           sq_diff = '0;
        endcase
        sq_abs = sq_diff[24] ? -sq_diff : sq_diff;
        sq_mag = sq_abs[23:0];
    end

    always_comb begin
        case (i_cmd.frc_src)
            plaf_pkg::FRC_MID: begin
                f_c = r_prev;
                f_l = r_bprev;
                f_r = r_x;
            end
            plaf_pkg::FRC_END: begin
                f_c = r_x;
                f_l = r_bprev;
                f_r = r_first;
            end
            default: begin
                f_c = r_first;
                f_l = r_x;
                f_r = r_second;
            end
        endcase
        f_c_abs = f_c[23] ? -{f_c[23], f_c} : {f_c[23], f_c};
    end

    assign coef = i_cmd.use_mass ? i_cfg.mass_coef : i_cfg.kinetic_coef;

    always_comb begin
        case (i_cmd.mul_op)
            plaf_pkg::MUL_SQ: begin
                mul_a = {8'd0, sq_mag};
                mul_b = {8'd0, sq_mag};
            end
            plaf_pkg::MUL_TLO: begin
                mul_a = r_sq[31:0];
                mul_b = coef;
            end
            plaf_pkg::MUL_THI: begin
                mul_a = {16'd0, r_sq[47:32]};
                mul_b = coef;
            end
            plaf_pkg::MUL_DIAG: begin
                mul_a = {8'd0, f_c_abs[23:0]};
                mul_b = i_cfg.force_diag;
            end
            plaf_pkg::MUL_FLO: begin
                mul_a = r_imag[31:0];
                mul_b = i_cfg.force_scale;
            end
            plaf_pkg::MUL_FHI: begin
                mul_a = {8'd0, r_imag[55:32]};
                mul_b = i_cfg.force_scale;
            end
            plaf_pkg::MUL_ALO: begin
                mul_a = r_sum[31:0];
                mul_b = i_cfg.action_scale;
            end
            plaf_pkg::MUL_AHI: begin
                mul_a = r_sum[63:32];
                mul_b = i_cfg.action_scale;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // c * diag - (l + r) in q.32
    assign fp_s      = r_cneg ? -{2'b00, r_fp} : {2'b00, r_fp};
    assign lr_sh     = {{16{r_lr[24]}}, r_lr, 16'd0};
    assign inner     = fp_s - lr_sh;
    assign inner_abs = inner[56] ? -inner : inner;

    // force to q16.16 with saturation
    assign frc_p   = {1'b0, r_phi[55:0]} + {25'd0, r_plo[63:32]};
    assign frc_big = |frc_p[56:31];
    always_comb begin
        if (r_ineg) begin
            frc_val = frc_big ? 64'hFFFF_FFFF_8000_0000 : (64'd0 - {33'd0, frc_p[30:0]});
        end else begin
            frc_val = frc_big ? 64'h0000_0000_7FFF_FFFF : {33'd0, frc_p[30:0]};
        end
    end

    // squared term to q32.32 and saturating accumulate
    assign term     = {r_phi[47:0], 16'd0} + {16'd0, r_plo[63:16]};
    assign acc_s    = {1'b0, r_sum} + {1'b0, term};
    assign sum_next = acc_s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_s[63:0];

    // action scaling with saturation
    assign act_tot = {1'b0, r_phi, 16'd0} + {33'd0, r_plo[63:16]};
    assign act_val = (|act_tot[80:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, act_tot[62:0]};

    assign out_free        = !r_ovalid || !i_out_stall;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_position;
        end
        if (i_cmd.shift) begin
            r_bprev <= r_prev;
            r_prev  <= r_x;
        end
        if (i_cmd.store_first) begin
            r_first <= r_x;
        end
        if (i_cmd.store_second) begin
            r_second <= r_x;
        end
        case (i_cmd.mul_op)
            plaf_pkg::MUL_SQ: begin
                r_sq <= mul_p[47:0];
            end
            plaf_pkg::MUL_DIAG: begin
                r_fp   <= mul_p[54:0];
                r_cneg <= f_c[23];
                r_lr   <= {f_l[23], f_l} + {f_r[23], f_r};
            end
            plaf_pkg::MUL_TLO, plaf_pkg::MUL_FLO, plaf_pkg::MUL_ALO: begin
                r_plo <= mul_p;
            end
            plaf_pkg::MUL_THI, plaf_pkg::MUL_FHI, plaf_pkg::MUL_AHI: begin
                r_phi <= mul_p;
            end
            default: begin
            end
        endcase
        if (i_cmd.inner) begin
            r_ineg <= inner[56];
            r_imag <= inner_abs[55:0];
        end
        if (i_cmd.emit_force) begin
            r_okind  <= 1'b0;
            r_osite  <= i_cmd.site;
            r_ovalue <= frc_val;
            r_olast  <= 1'b0;
        end else if (i_cmd.emit_action) begin
            r_okind  <= 1'b1;
            r_osite  <= '0;
            r_ovalue <= act_val;
            r_olast  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clear_sum) begin
                r_sum <= '0;
            end else if (i_cmd.acc) begin
                r_sum <= sum_next;
            end
            if (i_cmd.emit_force || i_cmd.emit_action) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_site        = r_osite;
    assign o_value       = r_ovalue;
    assign o_last        = r_olast;

endmodule

### design/plaf_checker.sv
// port-level checks on the result words of the top level
module plaf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_result_kind,
    input logic [plaf_pkg::SITE_W-1:0]         o_site,
    input logic signed [plaf_pkg::VALUE_W-1:0] o_value,
    input logic                                o_last
);

    // a stalled word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value) && $stable(o_site)
            && $stable(o_result_kind))
        else $error("result word changed under stall");

    // last marks the action word and nothing else
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == o_result_kind))
        else $error("last flag does not match result kind");

    // action word carries site zero and a non-negative value
    a_action_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> (o_site == '0) && !o_value[63])
        else $error("malformed action word");

    // force words stay inside the signed 32-bit range
    a_force_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_kind |-> (&o_value[63:31]) || !(|o_value[63:31]))
        else $error("force outside saturation range");

endmodule

bind periodic_lattice_action_and_force_top plaf_checker u_plaf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_kind (o_result_kind),
    .o_site        (o_site),
    .o_value       (o_value),
    .o_last        (o_last)
);
